// ===== hw/rtl/fixed_width_code_unpacker_macros.svh =====
// Assertion macros for the fixed-width code unpacker checker.
`ifndef FIXED_WIDTH_CODE_UNPACKER_MACROS_SVH
`define FIXED_WIDTH_CODE_UNPACKER_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define FWCU_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define FWCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/fwcu_pkg.sv =====
// Package with types, constants and helpers of the fixed-width code unpacker.
package fwcu_pkg;

  localparam int DATA_W          = 8;
  localparam int EW_W            = 4;
  localparam int SKIP_W          = 3;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  localparam logic [EW_W-1:0]   EW_RESET   = 4'd8;
  localparam logic [SKIP_W-1:0] SKIP_RESET = 3'd0;

  // Register indexes, taken from paddr[2].
  localparam logic REG_ELEMENT_WIDTH = 1'b0;
  localparam logic REG_SKIP_BITS     = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_DATA    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  // Width 0 behaves as 1 and widths above 8 behave as 8.
  function automatic logic [EW_W-1:0] eff_width(input logic [EW_W-1:0] ew);
    logic [EW_W-1:0] w;
    begin
      w = ew;
      if (ew == 4'd0) begin
        w = 4'd1;
      end else if (ew > 4'd8) begin
        w = 4'd8;
      end
      return w;
    end
  endfunction

endpackage

// ===== hw/rtl/fixed_width_code_unpacker.sv =====
// Top level of the fixed-width code unpacker.
//
// Input items carry a command: load writes one code-to-symbol table entry,
// data hands over one packed byte, restart clears the bit accumulator and the
// skip count. Data bytes are walked one bit per cycle, MSB first, while the
// bit engine is not frozen by out_stall; the next item is taken on the edge
// of the eighth step, so a new byte can enter while the last bit is walked.
// A load waits until the engine is idle and no table read is outstanding.
// Each completed code with a valid entry reads the table read port once;
// the read is held one hit back so the final symbol of a byte can carry last.
// A symbol passes through the held hit, the read stage and the output stage.
// Element width and skip count are written over the APB-style port; pready is
// always high and reads return the register value.
// Synchronous reset clears the valid bits, the accumulator and out_valid;
// table contents are undefined until loaded. When out_stall is high the
// output holds, the read stage fills, and then the bit engine freezes.
module fixed_width_code_unpacker #(
  parameter int TABLE_DEPTH = fwcu_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [fwcu_pkg::DATA_W-1:0]   in_packed_byte,
  input  logic [fwcu_pkg::DATA_W-1:0]   in_entry_symbol,
  input  logic [fwcu_pkg::DATA_W-1:0]   in_entry_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fwcu_pkg::DATA_W-1:0]   out_symbol,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fwcu_pkg::PADDR_W-1:0]  paddr,
  input  logic [fwcu_pkg::PDATA_W-1:0]  pwdata,
  output logic [fwcu_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [fwcu_pkg::DATA_W:0] DEPTH_LIM = (fwcu_pkg::DATA_W+1)'(TABLE_DEPTH);

  // Configuration registers.
  logic [fwcu_pkg::EW_W-1:0]   ew_r;
  logic [fwcu_pkg::SKIP_W-1:0] skip_r;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ew_r   <= fwcu_pkg::EW_RESET;
      skip_r <= fwcu_pkg::SKIP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        fwcu_pkg::REG_ELEMENT_WIDTH: ew_r   <= pwdata[fwcu_pkg::EW_W-1:0];
        fwcu_pkg::REG_SKIP_BITS:     skip_r <= pwdata[fwcu_pkg::SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fwcu_pkg::REG_ELEMENT_WIDTH:
        prdata = {{(fwcu_pkg::PDATA_W-fwcu_pkg::EW_W){1'b0}}, ew_r};
      fwcu_pkg::REG_SKIP_BITS:
        prdata = {{(fwcu_pkg::PDATA_W-fwcu_pkg::SKIP_W){1'b0}}, skip_r};
      default: prdata = '0;
    endcase
  end

  // Bit engine state.
  logic                        busy_r;
  logic [2:0]                  cnt_r;
  logic [fwcu_pkg::DATA_W-1:0] byte_r;
  logic [fwcu_pkg::DATA_W-1:0] acc_r;
  logic [3:0]                  held_r;
  logic [fwcu_pkg::SKIP_W-1:0] skipped_r;

  // Hit waiting for its table read, and the read and output stages.
  logic                        pend_valid_r;
  logic                        pend_done_r;
  logic [IDX_W-1:0]            pend_code_r;
  logic                        s1_valid_r;
  logic                        s1_last_r;
  logic [fwcu_pkg::DATA_W-1:0] rd_data_r;
  logic                        out_valid_r;
  logic                        out_last_r;
  logic [fwcu_pkg::DATA_W-1:0] out_symbol_r;

  logic [fwcu_pkg::DATA_W-1:0] mem_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]      entry_valid_r;

  logic                        out_ready;
  logic                        go;
  logic                        step;
  logic                        final_step;
  logic                        accept;
  logic                        acc_load;
  logic                        acc_data;
  logic                        acc_restart;
  logic                        load_in_range;
  logic                        do_skip;
  logic [fwcu_pkg::DATA_W-1:0] acc_nxt;
  logic [3:0]                  held_nxt;
  logic                        code_done;
  logic                        step_hit;
  logic                        issue;

  assign out_ready  = !out_valid_r || !out_stall;
  assign go         = !s1_valid_r || out_ready;
  assign step       = busy_r && go;
  assign final_step = (cnt_r == 3'd7);

  // A data byte may follow on the edge of the previous byte's last step.
  always_comb begin
    in_stall = busy_r && !(final_step && go);
    if (in_command == fwcu_pkg::CMD_LOAD && (busy_r || pend_valid_r)) begin
      in_stall = 1'b1;
    end
  end

  assign accept      = in_valid && !in_stall;
  assign acc_load    = accept && (in_command == fwcu_pkg::CMD_LOAD);
  assign acc_data    = accept && (in_command == fwcu_pkg::CMD_DATA);
  assign acc_restart = accept && (in_command == fwcu_pkg::CMD_RESTART);
  assign load_in_range = ({1'b0, in_entry_code} < DEPTH_LIM);

  always_comb begin
    do_skip   = (skipped_r < skip_r);
    acc_nxt   = {acc_r[fwcu_pkg::DATA_W-2:0], byte_r[fwcu_pkg::DATA_W-1]};
    held_nxt  = held_r + 4'd1;
    code_done = !do_skip && (held_nxt >= fwcu_pkg::eff_width(ew_r));
    step_hit  = step && code_done && ({1'b0, acc_nxt} < DEPTH_LIM) &&
                entry_valid_r[acc_nxt[IDX_W-1:0]];
  end

  // The held hit goes to the table once the next hit arrives or its byte ends.
  assign issue = go && pend_valid_r && (step_hit || pend_done_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (acc_data) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + 3'd1;
      if (final_step) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_data) begin
      byte_r <= in_packed_byte;
    end else if (step) begin
      byte_r <= {byte_r[fwcu_pkg::DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || acc_restart) begin
      acc_r     <= '0;
      held_r    <= '0;
      skipped_r <= '0;
    end else if (step) begin
      if (do_skip) begin
        skipped_r <= skipped_r + 3'd1;
      end else if (code_done) begin
        acc_r  <= '0;
        held_r <= '0;
      end else begin
        acc_r  <= acc_nxt;
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_done_r  <= 1'b0;
    end else if (go) begin
      if (step_hit) begin
        pend_valid_r <= 1'b1;
        pend_done_r  <= final_step;
      end else if (issue) begin
        pend_valid_r <= 1'b0;
      end else if (step && final_step && pend_valid_r) begin
        pend_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && step_hit) begin
      pend_code_r <= acc_nxt[IDX_W-1:0];
    end
  end

  // Table memory: one write port for loads, one read port for issued hits.
  always_ff @(posedge clk) begin
    if (acc_load && load_in_range) begin
      mem_r[in_entry_code[IDX_W-1:0]] <= in_entry_symbol;
    end
    if (issue) begin
      rd_data_r <= mem_r[pend_code_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
    end else if (acc_load && load_in_range) begin
      entry_valid_r[in_entry_code[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
    end else if (go) begin
      s1_valid_r <= issue;
      s1_last_r  <= pend_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_symbol_r <= rd_data_r;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule

// ===== hw/rtl/fwcu_checker.sv =====
// Port-level checker for the fixed-width code unpacker and its bind.
`include "fixed_width_code_unpacker_macros.svh"

module fwcu_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [1:0]                    in_command,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [fwcu_pkg::DATA_W-1:0]   out_symbol,
  input logic                          out_last,
  input logic                          pready
);

  // A held result keeps its payload.
  `FWCU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                    out_valid && $stable(out_symbol) && $stable(out_last))

  // A data byte keeps the bit engine busy for the following cycle.
  `FWCU_ASSERT_NEXT(a_data_busy, clk, rst_n,
                    in_valid && !in_stall && in_command == fwcu_pkg::CMD_DATA,
                    in_stall || in_command == fwcu_pkg::CMD_RESTART)

  // Nothing comes out in the cycle right after reset.
  `FWCU_ASSERT_NEXT(a_reset_quiet, clk, 1'b1, !rst_n, !out_valid)

  // The configuration port never inserts wait states.
  `FWCU_ASSERT_ALWAYS(a_pready, clk, rst_n, pready)

endmodule

bind fixed_width_code_unpacker fwcu_checker u_fwcu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_command (in_command),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_symbol (out_symbol),
  .out_last   (out_last),
  .pready     (pready)
);

// ===== dv/fixed_width_code_unpacker_tb.sv =====
// Self-checking testbench for the fixed-width code unpacker.
`timescale 1ns / 1ps

module fixed_width_code_unpacker_tb;

  localparam int          DEPTH        = fwcu_pkg::TABLE_DEPTH_DEF;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          MAX_REPORTS  = 10;
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 60;
  localparam logic [1:0]  CMD_UNKNOWN  = 2'd3;

  typedef struct {
    logic [1:0] command;
    logic [7:0] packed_byte;
    logic [7:0] entry_symbol;
    logic [7:0] entry_code;
  } unpack_item_t;

  typedef struct {
    logic [7:0] symbol;
    logic       last;
  } symbol_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [7:0]  in_packed_byte;
  logic [7:0]  in_entry_symbol;
  logic [7:0]  in_entry_code;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_symbol;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [fwcu_pkg::PADDR_W-1:0] paddr;
  logic [fwcu_pkg::PDATA_W-1:0] pwdata;
  logic [fwcu_pkg::PDATA_W-1:0] prdata;
  logic        pready;

  fixed_width_code_unpacker i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_packed_byte  (in_packed_byte),
    .in_entry_symbol (in_entry_symbol),
    .in_entry_code   (in_entry_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol      (out_symbol),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Decoder state mirrored by the testbench.
  logic [7:0]   tbl_sym   [0:DEPTH-1];
  bit           tbl_valid [0:DEPTH-1];
  logic [7:0]   code_acc;
  logic [3:0]   acc_bits;
  logic [2:0]   skip_count;
  logic [3:0]   cfg_width;
  logic [2:0]   cfg_skip;

  unpack_item_t pending_items[$];
  symbol_t      expected_symbols[$];
  unpack_item_t drv_item;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;
  bit  in_taken;
  int  cycle_count;
  int  mismatches;
  int  symbols_checked;
  int  items_accepted;
  int  settings_used;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Bit-serial decode of one accepted item; queues the symbols it produces.
  function automatic void decode_item(input unpack_item_t it);
    symbol_t    produced[$];
    symbol_t    sym;
    logic [3:0] w;
    case (it.command)
      fwcu_pkg::CMD_LOAD: begin
        if (int'(it.entry_code) < DEPTH) begin
          tbl_sym[it.entry_code]   = it.entry_symbol;
          tbl_valid[it.entry_code] = 1'b1;
        end
      end
      fwcu_pkg::CMD_RESTART: begin
        code_acc   = '0;
        acc_bits   = '0;
        skip_count = '0;
      end
      fwcu_pkg::CMD_DATA: begin
        w = (cfg_width == 4'd0) ? 4'd1 : ((cfg_width > 4'd8) ? 4'd8 : cfg_width);
        for (int i = 7; i >= 0; i--) begin
          if (skip_count < cfg_skip) begin
            skip_count = skip_count + 3'd1;
          end else begin
            code_acc = {code_acc[6:0], it.packed_byte[i]};
            acc_bits = acc_bits + 4'd1;
            if (acc_bits >= w) begin
              if (int'(code_acc) < DEPTH && tbl_valid[code_acc]) begin
                sym.symbol = tbl_sym[code_acc];
                sym.last   = 1'b0;
                produced   = {produced, sym};
              end
              code_acc = '0;
              acc_bits = '0;
            end
          end
        end
        if (produced.size() > 0) begin
          produced[produced.size()-1].last = 1'b1;
        end
        foreach (produced[k]) begin
          expected_symbols = {expected_symbols, produced[k]};
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void note_mismatch(input string field, input int exp_v, input int act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("Mismatch on %s at cycle %0d: expected 0x%0h, got 0x%0h",
               field, cycle_count, exp_v, act_v);
    end
  endfunction

  // Input driver: a new item is offered only once the current one has gone in.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_item = pending_items.pop_front();
        in_valid        <= 1'b1;
        in_command      <= drv_item.command;
        in_packed_byte  <= drv_item.packed_byte;
        in_entry_symbol <= drv_item.entry_symbol;
        in_entry_code   <= drv_item.entry_code;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Input side: every accepted item updates the prediction.
  always @(posedge clk) begin
    unpack_item_t it;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      it.command      = in_command;
      it.packed_byte  = in_packed_byte;
      it.entry_symbol = in_entry_symbol;
      it.entry_code   = in_entry_code;
      items_accepted++;
      decode_item(it);
    end
  end

  // Output side: each accepted symbol is checked against the oldest expectation.
  always @(posedge clk) begin
    symbol_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_symbols.size() == 0) begin
        note_mismatch("unexpected symbol", 0, int'(out_symbol));
      end else begin
        want = expected_symbols.pop_front();
        symbols_checked++;
        if (out_symbol !== want.symbol) begin
          note_mismatch("symbol", int'(want.symbol), int'(out_symbol));
        end
        if (out_last !== want.last) begin
          note_mismatch("last", int'(want.last), int'(out_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d symbols still expected",
               cycle_count, expected_symbols.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_item(input logic [1:0] cmd, input logic [7:0] pb,
                            input logic [7:0] sym, input logic [7:0] code);
    unpack_item_t it;
    it.command      = cmd;
    it.packed_byte  = pb;
    it.entry_symbol = sym;
    it.entry_code   = code;
    pending_items   = {pending_items, it};
  endtask

  task automatic cfg_write(input logic reg_idx, input logic [fwcu_pkg::PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_idx == fwcu_pkg::REG_ELEMENT_WIDTH) begin
      cfg_width = value[3:0];
    end else begin
      cfg_skip = value[2:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // A load or a data byte without hits yields nothing, so idle a while after
  // the last symbol before touching the registers.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || hold_off ||
           expected_symbols.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input int mode);
    case (mode)
      1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
      3:       begin send_idle_pct = 17; recv_stall_pct = 17; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic configure(input logic [3:0] width, input logic [2:0] skip);
    wait_drained();
    cfg_write(fwcu_pkg::REG_ELEMENT_WIDTH, {28'd0, width});
    cfg_write(fwcu_pkg::REG_SKIP_BITS, {29'd0, skip});
    settings_used++;
  endtask

  // Table loads for the current width, then mostly data bytes, with restarts,
  // further loads, loads with full-byte codes and unknown commands mixed in.
  task automatic fill_phase(input int n_items);
    int         w;
    int         n_load;
    int         r;
    logic [7:0] mask;
    w      = (cfg_width == 4'd0) ? 1 : ((cfg_width > 4'd8) ? 8 : int'(cfg_width));
    mask   = 8'((1 << w) - 1);
    n_load = (w <= 3) ? (1 << w) : 8;
    for (int j = 0; j < n_load; j++) begin
      queue_item(fwcu_pkg::CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom) & mask);
    end
    for (int j = n_load; j < n_items; j++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        queue_item(fwcu_pkg::CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom) & mask);
      end else if (r < 10) begin
        queue_item(fwcu_pkg::CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (r < 13) begin
        queue_item(fwcu_pkg::CMD_RESTART, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (r < 15) begin
        queue_item(CMD_UNKNOWN, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        queue_item(fwcu_pkg::CMD_DATA, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [3:0] ph_width [PHASES];
    logic [2:0] ph_skip  [PHASES];
    ph_width        = '{4'd3, 4'd8, 4'd2, 4'd15, 4'd1, 4'd5, 4'd0, 4'd7};
    ph_skip         = '{3'd5, 3'd0, 3'd7, 3'd2, 3'd0, 3'd3, 3'd1, 3'd6};
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_command      = fwcu_pkg::CMD_RESTART;
    in_packed_byte  = '0;
    in_entry_symbol = '0;
    in_entry_code   = '0;
    out_stall       = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    hold_off        = 1'b0;
    in_taken        = 1'b0;
    cycle_count     = 0;
    mismatches      = 0;
    symbols_checked = 0;
    items_accepted  = 0;
    settings_used   = 1;
    code_acc        = '0;
    acc_bits        = '0;
    skip_count      = '0;
    cfg_width       = fwcu_pkg::EW_RESET;
    cfg_skip        = fwcu_pkg::SKIP_RESET;
    foreach (tbl_valid[k]) begin
      tbl_valid[k] = 1'b0;
      tbl_sym[k]   = '0;
    end
    set_mode(0);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset widths: full-byte codes, overwrite of an entry, a miss,
    // an unknown command and a restart.
    queue_item(fwcu_pkg::CMD_LOAD, 8'h00, 8'hFF, 8'h00);
    queue_item(fwcu_pkg::CMD_LOAD, 8'hFF, 8'h00, 8'hFF);
    queue_item(fwcu_pkg::CMD_LOAD, 8'h00, 8'h5A, 8'hA5);
    queue_item(fwcu_pkg::CMD_LOAD, 8'h00, 8'h3C, 8'hA5);
    queue_item(fwcu_pkg::CMD_LOAD, 8'h00, 8'hA5, 8'h5A);
    queue_item(fwcu_pkg::CMD_DATA, 8'h00, 8'hFF, 8'hFF);
    queue_item(fwcu_pkg::CMD_DATA, 8'hFF, 8'h00, 8'h00);
    queue_item(fwcu_pkg::CMD_DATA, 8'hA5, 8'h00, 8'h00);
    queue_item(fwcu_pkg::CMD_DATA, 8'h5A, 8'h00, 8'h00);
    queue_item(fwcu_pkg::CMD_DATA, 8'h12, 8'h00, 8'h00);
    queue_item(CMD_UNKNOWN, 8'hFF, 8'hFF, 8'hFF);
    queue_item(fwcu_pkg::CMD_RESTART, 8'hFF, 8'hFF, 8'hFF);

    // One-bit codes give eight symbols per byte.
    configure(4'd1, 3'd0);
    queue_item(fwcu_pkg::CMD_LOAD, 8'h00, 8'h11, 8'h00);
    queue_item(fwcu_pkg::CMD_LOAD, 8'h00, 8'hEE, 8'h01);
    queue_item(fwcu_pkg::CMD_DATA, 8'h55, 8'h00, 8'h00);
    queue_item(fwcu_pkg::CMD_DATA, 8'hFF, 8'h00, 8'h00);

    // Width zero behaves as one; the longest skip eats most of the first byte.
    configure(4'd0, 3'd7);
    queue_item(fwcu_pkg::CMD_RESTART, 8'h00, 8'h00, 8'h00);
    queue_item(fwcu_pkg::CMD_DATA, 8'h80, 8'h00, 8'h00);
    queue_item(fwcu_pkg::CMD_DATA, 8'h01, 8'h00, 8'h00);

    // Widths above eight behave as eight; this leaves a partial code behind
    // so the next setting changes width in the middle of a code.
    configure(4'd15, 3'd3);
    queue_item(fwcu_pkg::CMD_RESTART, 8'h00, 8'h00, 8'h00);
    queue_item(fwcu_pkg::CMD_LOAD, 8'h00, 8'h77, 8'hF8);
    queue_item(fwcu_pkg::CMD_DATA, 8'hFF, 8'h00, 8'h00);
    queue_item(fwcu_pkg::CMD_DATA, 8'h00, 8'h00, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      configure(ph_width[p], ph_skip[p]);
      set_mode(p % 4);
      fill_phase(PHASE_ITEMS);
      if (p == 4) begin
        // Long receiver hold-off while the sender keeps offering items.
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
    end

    wait_drained();
    if (expected_symbols.size() != 0) begin
      note_mismatch("symbols left over", 0, expected_symbols.size());
    end
    $display("Accepted %0d items under %0d register settings, checked %0d symbols.",
             items_accepted, settings_used, symbols_checked);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/fwcu_pkg.sv
hw/rtl/fixed_width_code_unpacker.sv
hw/rtl/fwcu_checker.sv
dv/fixed_width_code_unpacker_tb.sv
